>>> hdl/quaternion_vector_rotator_top_macros.svh
// Assertion helpers for the rotator. Each use expects clk and arst_n in scope.
`ifndef QUATERNION_VECTOR_ROTATOR_TOP_MACROS_SVH
`define QUATERNION_VECTOR_ROTATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QVR_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/qvr_pkg.sv
`default_nettype none
package qvr_pkg;

	localparam int QUAT_W   = 16;   // Q2.14 component
	localparam int PROD_W   = 2 * QUAT_W;
	localparam int MAT_W    = PROD_W + 2;   // 2*(a*b +- c*d) needs two more bits
	localparam int VEC_W    = 32;
	localparam int VL_W     = 16;           // low half of a vector component, unsigned
	localparam int VH_W     = VEC_W - VL_W;
	localparam int PH_W     = MAT_W + VH_W;
	localparam int PL_W     = MAT_W + VL_W + 1;
	localparam int HI_W     = PH_W + 2;     // sum of three terms
	localparam int LO_W     = PL_W + 2;
	localparam int ACC_W    = HI_W + VL_W + 2;
	localparam int QUAT_SHIFT = 28;         // matrix entries carry scale 2^-28
	localparam int Q_W      = ACC_W - QUAT_SHIFT;

	typedef logic signed [QUAT_W-1:0] quat_c_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [MAT_W-1:0]  mat_t;
	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [PH_W-1:0]   ph_t;
	typedef logic signed [PL_W-1:0]   pl_t;
	typedef logic signed [HI_W-1:0]   hi_t;
	typedef logic signed [LO_W-1:0]   lo_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef vec_t [2:0]       vec3_t;
	typedef mat_t [8:0]       mat3_t;   // row-major, entry 3*row+col
	typedef hi_t  [2:0]       hi3_t;
	typedef lo_t  [2:0]       lo3_t;

	typedef struct packed {
		quat_c_t s;
		quat_c_t b;
		quat_c_t c;
		quat_c_t d;
	} quat_t;

	typedef enum logic [1:0] {
		CMD_VEC    = 2'd0,
		CMD_AXIS_X = 2'd1,
		CMD_AXIS_Y = 2'd2,
		CMD_AXIS_Z = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SCALAR = 2'd0,
		REG_I      = 2'd1,
		REG_J      = 2'd2,
		REG_K      = 2'd3
	} reg_idx_t;

	localparam quat_c_t QUAT_S_RST = 16'sd16384;

	localparam acc_t ROUND_BIAS =
		{{(ACC_W-QUAT_SHIFT){1'b0}}, 1'b1, {(QUAT_SHIFT-1){1'b0}}};

	localparam logic signed [Q_W-1:0] Q_MAX =
		{{(Q_W-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN =
		{{(Q_W-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};

endpackage
`default_nettype wire

>>> hdl/qvr_cfg.sv
`default_nettype none
module qvr_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output qvr_pkg::quat_t   quat
);

	qvr_pkg::quat_t   quat_q;
	qvr_pkg::reg_idx_t idx;
	logic             wr;

	assign idx = qvr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.s <= qvr_pkg::QUAT_S_RST;
			quat_q.b <= '0;
			quat_q.c <= '0;
			quat_q.d <= '0;
		end else if (wr) begin
			unique case (idx)
				qvr_pkg::REG_SCALAR: quat_q.s <= pwdata[15:0];
				qvr_pkg::REG_I:      quat_q.b <= pwdata[15:0];
				qvr_pkg::REG_J:      quat_q.c <= pwdata[15:0];
				qvr_pkg::REG_K:      quat_q.d <= pwdata[15:0];
				default:             quat_q   <= quat_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			qvr_pkg::REG_SCALAR: prdata = {16'h0000, quat_q.s};
			qvr_pkg::REG_I:      prdata = {16'h0000, quat_q.b};
			qvr_pkg::REG_J:      prdata = {16'h0000, quat_q.c};
			qvr_pkg::REG_K:      prdata = {16'h0000, quat_q.d};
			default:             prdata = '0;
		endcase
	end

	assign quat = quat_q;

endmodule
`default_nettype wire

>>> hdl/qvr_matrix.sv
`default_nettype none
module qvr_matrix #(
	parameter int VEC_FRAC_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [1:0]     cmd,
	input  wire logic           inverse,
	input  wire qvr_pkg::vec3_t vec,
	input  wire qvr_pkg::quat_t quat,
	output logic                valid_s2,
	output qvr_pkg::mat3_t      mat_s2,
	output qvr_pkg::vec3_t      vec_s2
);

	localparam int MW = qvr_pkg::MAT_W;
	localparam int PW = qvr_pkg::PROD_W;

	localparam qvr_pkg::vec_t AXIS_ONE =
		{{(qvr_pkg::VEC_W-1-VEC_FRAC_BITS){1'b0}}, 1'b1, {VEC_FRAC_BITS{1'b0}}};

	// stage 1: quaternion products, operand select
	qvr_pkg::prod_t ss_s1, bb_s1, cc_s1, dd_s1, bc_s1, bd_s1, cd_s1, sb_s1, sc_s1, sd_s1;
	qvr_pkg::vec3_t vec_s1;
	qvr_pkg::vec3_t vsel;
	logic           inv_s1;
	logic           valid_s1;

	always_comb begin
		vsel = '0;
		unique case (qvr_pkg::cmd_t'(cmd))
			qvr_pkg::CMD_VEC:    vsel = vec;
			qvr_pkg::CMD_AXIS_X: vsel[0] = AXIS_ONE;
			qvr_pkg::CMD_AXIS_Y: vsel[1] = AXIS_ONE;
			qvr_pkg::CMD_AXIS_Z: vsel[2] = AXIS_ONE;
			default:             vsel = vec;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s1  <= PW'(quat.s) * PW'(quat.s);
			bb_s1  <= PW'(quat.b) * PW'(quat.b);
			cc_s1  <= PW'(quat.c) * PW'(quat.c);
			dd_s1  <= PW'(quat.d) * PW'(quat.d);
			bc_s1  <= PW'(quat.b) * PW'(quat.c);
			bd_s1  <= PW'(quat.b) * PW'(quat.d);
			cd_s1  <= PW'(quat.c) * PW'(quat.d);
			sb_s1  <= PW'(quat.s) * PW'(quat.b);
			sc_s1  <= PW'(quat.s) * PW'(quat.c);
			sd_s1  <= PW'(quat.s) * PW'(quat.d);
			vec_s1 <= vsel;
			inv_s1 <= inverse;
		end
	end

	// stage 2: matrix entries; the conjugate flips the sign of the s*u terms
	logic signed [MW-1:0] ss, bb, cc, dd, bc, bd, cd, sb, sc, sd;
	logic signed [MW-1:0] t01, t02, t10, t12, t20, t21;
	qvr_pkg::mat3_t       mat;

	always_comb begin
		ss = MW'(ss_s1);
		bb = MW'(bb_s1);
		cc = MW'(cc_s1);
		dd = MW'(dd_s1);
		bc = MW'(bc_s1);
		bd = MW'(bd_s1);
		cd = MW'(cd_s1);
		sb = MW'(sb_s1);
		sc = MW'(sc_s1);
		sd = MW'(sd_s1);
		t01 = inv_s1 ? (bc + sd) : (bc - sd);
		t02 = inv_s1 ? (bd - sc) : (bd + sc);
		t10 = inv_s1 ? (bc - sd) : (bc + sd);
		t12 = inv_s1 ? (cd + sb) : (cd - sb);
		t20 = inv_s1 ? (bd + sc) : (bd - sc);
		t21 = inv_s1 ? (cd - sb) : (cd + sb);
		mat[0] = ss + bb - cc - dd;
		mat[1] = t01 <<< 1;
		mat[2] = t02 <<< 1;
		mat[3] = t10 <<< 1;
		mat[4] = ss - bb + cc - dd;
		mat[5] = t12 <<< 1;
		mat[6] = t20 <<< 1;
		mat[7] = t21 <<< 1;
		mat[8] = ss - bb - cc + dd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s2 <= mat;
			vec_s2 <= vec_s1;
		end
	end

endmodule
`default_nettype wire

>>> hdl/qvr_dot.sv
`default_nettype none
module qvr_dot (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire qvr_pkg::mat3_t mat,
	input  wire qvr_pkg::vec3_t vec,
	output logic                valid_s4,
	output qvr_pkg::hi3_t       hi_s4,
	output qvr_pkg::lo3_t       lo_s4
);

	localparam int VL = qvr_pkg::VL_W;
	localparam int VW = qvr_pkg::VEC_W;

	// stage 3: each entry times the signed high and unsigned low half of v
	qvr_pkg::ph_t ph_s3 [9];
	qvr_pkg::pl_t pl_s3 [9];
	logic         valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 9; e++) begin
				ph_s3[e] <= qvr_pkg::PH_W'($signed(mat[e]))
					* qvr_pkg::PH_W'($signed(vec[e % 3][VW-1:VL]));
				pl_s3[e] <= qvr_pkg::PL_W'($signed(mat[e]))
					* qvr_pkg::PL_W'($signed({1'b0, vec[e % 3][VL-1:0]}));
			end
		end
	end

	// stage 4: row sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				hi_s4[r] <= qvr_pkg::HI_W'(ph_s3[3*r]) + qvr_pkg::HI_W'(ph_s3[3*r+1])
					+ qvr_pkg::HI_W'(ph_s3[3*r+2]);
				lo_s4[r] <= qvr_pkg::LO_W'(pl_s3[3*r]) + qvr_pkg::LO_W'(pl_s3[3*r+1])
					+ qvr_pkg::LO_W'(pl_s3[3*r+2]);
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/qvr_round.sv
`default_nettype none
module qvr_round (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire qvr_pkg::hi3_t hi,
	input  wire qvr_pkg::lo3_t lo,
	output logic               valid_s5,
	output qvr_pkg::vec3_t     rot_s5,
	output logic               sat_s5
);

	localparam int AW = qvr_pkg::ACC_W;
	localparam int QW = qvr_pkg::Q_W;

	qvr_pkg::acc_t         acc [3];
	logic signed [QW-1:0]  q   [3];
	qvr_pkg::vec3_t        rot;
	logic [2:0]            clip;

	// round half up at 2^-28, then clip to 32 bits
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = (AW'($signed(hi[r])) <<< qvr_pkg::VL_W) + AW'($signed(lo[r]))
				+ qvr_pkg::ROUND_BIAS;
			q[r] = acc[r][AW-1:qvr_pkg::QUAT_SHIFT];
			if (q[r] > qvr_pkg::Q_MAX) begin
				rot[r]  = qvr_pkg::VEC_W'(qvr_pkg::Q_MAX);
				clip[r] = 1'b1;
			end else if (q[r] < qvr_pkg::Q_MIN) begin
				rot[r]  = qvr_pkg::VEC_W'(qvr_pkg::Q_MIN);
				clip[r] = 1'b1;
			end else begin
				rot[r]  = q[r][qvr_pkg::VEC_W-1:0];
				clip[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s5 <= rot;
			sat_s5 <= |clip;
		end
	end

endmodule
`default_nettype wire

>>> hdl/quaternion_vector_rotator_top.sv
// Channel  | Dir | Word                                             | Handshake
// ---------+-----+--------------------------------------------------+---------------------
// s_axis   | in  | tdata: vec_x, vec_y, vec_z; tuser: cmd, inverse   | tvalid / tready
// m_axis   | out | tdata: rot_x, rot_y, rot_z; tuser: saturated      | tvalid / tready
// apb      | in  | quat_scalar, quat_i, quat_j, quat_k at 0x0..0xC   | psel/penable, pready=1
//
// One word per cycle while the sink takes words; each word passes five register stages on
// its way from s_axis to m_axis.
// The five stages are: quaternion products, matrix entries, partial products against the
// split vector, row sums, and the final round-and-clip add.
// A single enable moves the whole pipeline; it drops only when the output stage holds a
// word that the sink does not take, and s_axis_tready follows it.
// Reset (arst_n low) clears every valid bit and loads the identity quaternion.
`default_nettype none
`include "quaternion_vector_rotator_top_macros.svh"
module quaternion_vector_rotator_top #(
	parameter int VEC_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,   // [31:0] vec_x, [63:32] vec_y, [95:64] vec_z
	input  wire logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] inverse
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,   // [31:0] rot_x, [63:32] rot_y, [95:64] rot_z
	output logic [0:0]       m_axis_tuser    // [0] saturated
);

	qvr_pkg::quat_t quat;
	qvr_pkg::vec3_t vec_in;
	qvr_pkg::vec3_t vec_s2;
	qvr_pkg::mat3_t mat_s2;
	qvr_pkg::hi3_t  hi_s4;
	qvr_pkg::lo3_t  lo_s4;
	qvr_pkg::vec3_t rot_s5;
	logic           valid_s2, valid_s4, valid_s5;
	logic           sat_s5;
	logic           pipe_en;

	// advance everything unless the output word is stuck
	assign pipe_en       = !valid_s5 || m_axis_tready;
	assign s_axis_tready = pipe_en;
	assign pready        = 1'b1;

	assign vec_in[0] = s_axis_tdata[31:0];
	assign vec_in[1] = s_axis_tdata[63:32];
	assign vec_in[2] = s_axis_tdata[95:64];

	qvr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.quat    (quat)
	);

	// stages 1-2: rotation matrix at scale 2^-28, operand select
	qvr_matrix #(
		.VEC_FRAC_BITS (VEC_FRAC_BITS)
	) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (s_axis_tvalid),
		.cmd      (s_axis_tuser[1:0]),
		.inverse  (s_axis_tuser[2]),
		.vec      (vec_in),
		.quat     (quat),
		.valid_s2 (valid_s2),
		.mat_s2   (mat_s2),
		.vec_s2   (vec_s2)
	);

	// stages 3-4: exact R*v as high and low partial sums
	qvr_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (valid_s2),
		.mat      (mat_s2),
		.vec      (vec_s2),
		.valid_s4 (valid_s4),
		.hi_s4    (hi_s4),
		.lo_s4    (lo_s4)
	);

	// stage 5: merge, round, clip; this register is the output word
	qvr_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (valid_s4),
		.hi       (hi_s4),
		.lo       (lo_s4),
		.valid_s5 (valid_s5),
		.rot_s5   (rot_s5),
		.sat_s5   (sat_s5)
	);

	assign m_axis_tvalid   = valid_s5;
	assign m_axis_tdata    = {rot_s5[2], rot_s5[1], rot_s5[0]};
	assign m_axis_tuser[0] = sat_s5;

	// a held output word must not move while the pipeline is frozen
	`QVR_ASSERT_NEXT(a_stall_freezes, !pipe_en, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "pipeline moved while stalled")

	// a clipped word carries at least one component at a limit
	`QVR_ASSERT_HOLDS(a_sat_at_limit, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000 || m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000 || m_axis_tdata[95:64] == 32'h7fffffff || m_axis_tdata[95:64] == 32'h80000000, "saturated without a clipped component")

	// a scalar write lands in the quaternion register
	`QVR_ASSERT_NEXT(a_cfg_scalar, psel && penable && pwrite && paddr[3:2] == qvr_pkg::REG_SCALAR, quat.s == $past(pwdata[15:0]), "scalar register not written")

	// an accepted word shows up once the pipeline has advanced through every stage with no stall
	`QVR_ASSERT_HOLDS(a_latency, $past(s_axis_tvalid && pipe_en, 5) && $past(pipe_en, 4) && $past(pipe_en, 3) && $past(pipe_en, 2) && $past(pipe_en, 1), m_axis_tvalid, "accepted word lost in pipeline")

endmodule
`default_nettype wire
